// ===== src/tvas_pkg.sv =====
// shared constants, beat layouts and per-voice helper functions for the
// three-voice envelope synth; no dependencies
package tvas_pkg;

  localparam int NUM_VOICES = 3;
  localparam int SLOT_W     = $clog2(NUM_VOICES + 1);
  localparam int SAMPLE_W   = 8;
  localparam int VOICE_W    = 2;
  localparam int IN_DATA_W  = 128;
  localparam int DIV_W      = 8;

  localparam logic [DIV_W-1:0] ENV_RESET_COUNT = 8'd10;
  localparam logic [15:0]      LFSR_SEED       = 16'hACE1;
  localparam logic [15:0]      LFSR_TAPS       = 16'hB400;

  // beat kinds carried in s_tuser
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_NOTE = 1'b1;

  // waveform codes
  localparam logic [2:0] WAVE_OFF    = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_SAW    = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;
  localparam logic [2:0] WAVE_HOLD   = 3'd5;

  // envelope modes
  localparam logic [1:0] MODE_NONE = 2'd0;

  // envelope phases
  localparam logic [1:0] ENV_IDLE    = 2'd0;
  localparam logic [1:0] ENV_ATTACK  = 2'd1;
  localparam logic [1:0] ENV_DECAY   = 2'd2;
  localparam logic [1:0] ENV_RELEASE = 2'd3;

  // note-start beat, last field (voice) in the lowest bits
  typedef struct packed {
    logic              pad;
    logic [15:0]       bend_rate;
    logic [15:0]       bend_limit;
    logic [15:0]       release_rate;
    logic [15:0]       sustain_level;
    logic [15:0]       decay_rate;
    logic [15:0]       attack_rate;
    logic [7:0]        volume;
    logic [15:0]       phase_inc;
    logic [1:0]        env_mode;
    logic [2:0]        wave;
    logic [VOICE_W-1:0] voice;
  } note_t;

  typedef struct packed {
    logic [2:0]  wave;
    logic [1:0]  env_mode;
    logic [15:0] inc;
    logic [15:0] peak;
    logic [15:0] attack;
    logic [15:0] decay;
    logic [15:0] sustain;
    logic [15:0] release_rate;
    logic [15:0] bend_limit;
    logic [15:0] bend_rate;
  } voice_cfg_t;

  typedef struct packed {
    logic [15:0] level;
    logic [1:0]  phase;
  } env_t;

  // one ADSR step
  function automatic env_t env_step(env_t cur, voice_cfg_t c);
    logic [16:0] rise;
    logic [16:0] floor_lvl;
    env_t        nx;
    nx        = cur;
    rise      = {1'b0, cur.level} + {1'b0, c.attack};
    floor_lvl = {1'b0, c.sustain} + {1'b0, c.decay};
    case (cur.phase)
      ENV_ATTACK: begin
        if (cur.level >= c.peak) begin
          if (c.decay != 16'd0) begin
            nx.level = c.peak;
            nx.phase = ENV_DECAY;
          end else begin
            nx.level = c.sustain;
            nx.phase = ENV_RELEASE;
          end
        end else begin
          nx.level = rise[16] ? 16'hFFFF : rise[15:0];
        end
      end
      ENV_DECAY: begin
        if ({1'b0, cur.level} >= floor_lvl) begin
          nx.level = cur.level - c.decay;
        end else begin
          nx.level = c.sustain;
          nx.phase = ENV_RELEASE;
        end
      end
      ENV_RELEASE: begin
        if (cur.level >= c.sustain) begin
          if (c.env_mode[1]) begin
            nx.level = (c.attack != 16'd0) ? 16'd0 : c.peak;
            nx.phase = ENV_ATTACK;
          end else begin
            nx.level = 16'd0;
            nx.phase = ENV_IDLE;
          end
        end else begin
          nx.level = cur.level - c.release_rate;
        end
      end
      default: ;
    endcase
    return nx;
  endfunction

  // linear bend toward the limit, clamped there
  function automatic logic [15:0] bend_step(logic [15:0] bend, voice_cfg_t c);
    logic signed [16:0] b;
    logic signed [16:0] rate;
    logic signed [16:0] lim;
    rate = $signed({c.bend_rate[15], c.bend_rate});
    lim  = $signed({c.bend_limit[15], c.bend_limit});
    b    = $signed({bend[15], bend}) + rate;
    if (rate > 17'sd0 && b > lim) begin
      b = lim;
    end else if (rate < 17'sd0 && b < lim) begin
      b = lim;
    end
    return b[15:0];
  endfunction

  // waveform value for a phase; noise takes the already stepped lfsr
  function automatic logic [15:0] wave_shape(logic [2:0] wave, logic [15:0] ph,
                                             logic [15:0] held, logic [15:0] noise);
    logic [15:0] w;
    case (wave)
      WAVE_SQUARE: w = ph[15] ? 16'h0000 : 16'hFFFF;
      WAVE_SAW:    w = {ph[14:0], 1'b0};
      WAVE_TRI:    w = ph[15] ? {~ph[14:0], 1'b0} : {ph[14:0], 1'b0};
      WAVE_NOISE:  w = ph[15] ? 16'h0000 : noise;
      WAVE_HOLD:   w = held;
      WAVE_OFF:    w = 16'h0000;
      default:     w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

// ===== src/three_voice_adsr_synth.sv =====
// three-voice phase accumulator synth with adsr envelopes and pitch bend
// depends on tvas_pkg
//
//  channel  | signals                          | beat carries
//  ---------+----------------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | tick, or note start for one voice
//  output   | m_tvalid m_tready m_tdata        | one 8-bit sample per tick
//  config   | cfg_wr_en cfg_wr_data            | envelope divider
//
// one beat is taken every cycle unless a tick waits; a tick's sample goes via the
// input register, then the single processing pass into the output register
// note-start beats give no sample and never wait on the output side
// a tick waits in the input register only while the output register is full and stalled
// reset clears all voice state and loads the envelope divider and countdown with ten
module three_voice_adsr_synth (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // voice, wave, env_mode, phase_inc, volume, attack_rate, decay_rate,
  // sustain_level, release_rate, bend_limit, bend_rate, one zero pad bit
  input  logic [tvas_pkg::IN_DATA_W-1:0]    s_tdata,
  // action
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // sample
  output logic [tvas_pkg::SAMPLE_W-1:0]     m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [tvas_pkg::DIV_W-1:0]        cfg_wr_data
);
  import tvas_pkg::*;

  // input register
  logic        in_valid;
  logic        in_action;
  note_t       in_note;

  // voice state
  voice_cfg_t  cfg         [NUM_VOICES];
  logic [15:0] phase_count [NUM_VOICES];
  logic [15:0] wave_value  [NUM_VOICES];
  env_t        env         [NUM_VOICES];
  logic [15:0] bend_now    [NUM_VOICES];

  voice_cfg_t  cfg_next         [NUM_VOICES];
  logic [15:0] phase_count_next [NUM_VOICES];
  logic [15:0] wave_value_next  [NUM_VOICES];
  env_t        env_next         [NUM_VOICES];
  logic [15:0] bend_now_next    [NUM_VOICES];

  // shared state
  logic [SLOT_W-1:0]   slot_counter;
  logic [SLOT_W-1:0]   slot_counter_next;
  logic [DIV_W-1:0]    env_countdown;
  logic [DIV_W-1:0]    env_countdown_next;
  logic [DIV_W-1:0]    envelope_divider;
  logic [SAMPLE_W-1:0] last_sample;
  logic [SAMPLE_W-1:0] last_sample_next;
  logic [15:0]         noise_lfsr;
  logic [15:0]         noise_lfsr_next;
  logic [15:0]         lfsr_stepped;

  logic        proc_fire;
  logic        do_tick;
  logic        do_note;
  logic        render_slot;
  logic        env_fire;
  logic [15:0] rend_wave;
  logic [15:0] rend_level;
  logic [15:0] mix_product;
  logic [15:0] peak_new;

  // a note start never needs the output register, a tick needs a free one
  assign proc_fire = in_valid && (in_action == ACT_NOTE || !m_tvalid || m_tready);
  assign do_tick   = proc_fire && in_action == ACT_TICK;
  assign do_note   = proc_fire && in_action == ACT_NOTE;
  assign s_tready  = !in_valid || proc_fire;

  // slots 0..NUM_VOICES-1 render a voice, the last slot steps the envelopes
  assign render_slot = 32'(slot_counter) < NUM_VOICES;
  assign env_fire    = !render_slot && env_countdown == '0;

  assign lfsr_stepped = {1'b0, noise_lfsr[15:1]} ^ (noise_lfsr[0] ? LFSR_TAPS : 16'h0000);
  assign peak_new     = {in_note.volume, 8'h00};

  always_comb begin
    rend_wave       = 16'h0000;
    rend_level      = 16'h0000;
    noise_lfsr_next = noise_lfsr;
    for (int k = 0; k < NUM_VOICES; k++) begin
      cfg_next[k]         = cfg[k];
      phase_count_next[k] = phase_count[k];
      wave_value_next[k]  = wave_value[k];
      env_next[k]         = env[k];
      bend_now_next[k]    = bend_now[k];
      if (do_tick) begin
        // phase advance: increment plus bend / 256, sign kept
        phase_count_next[k] = phase_count[k] + cfg[k].inc
                              + {{8{bend_now[k][15]}}, bend_now[k][15:8]};
        if (render_slot && 32'(slot_counter) == k) begin
          wave_value_next[k] = wave_shape(cfg[k].wave, phase_count_next[k],
                                          wave_value[k], lfsr_stepped);
          rend_wave  = wave_value_next[k];
          rend_level = env[k].level;
          if (cfg[k].wave == WAVE_NOISE && !phase_count_next[k][15]) begin
            noise_lfsr_next = lfsr_stepped;
          end
        end
        if (env_fire) begin
          env_next[k]      = env_step(env[k], cfg[k]);
          bend_now_next[k] = bend_step(bend_now[k], cfg[k]);
        end
      end else if (do_note && 32'(in_note.voice) == k) begin
        // note start reprograms this voice; out-of-range voices match nothing
        cfg_next[k].wave     = in_note.wave;
        cfg_next[k].env_mode = in_note.env_mode;
        cfg_next[k].inc      = in_note.phase_inc;
        cfg_next[k].peak     = peak_new;
        phase_count_next[k]  = 16'h0000;
        if (in_note.env_mode != MODE_NONE) begin
          cfg_next[k].attack       = in_note.attack_rate;
          cfg_next[k].decay        = in_note.decay_rate;
          cfg_next[k].sustain      = in_note.sustain_level;
          cfg_next[k].release_rate = in_note.release_rate;
          env_next[k].phase        = ENV_ATTACK;
          env_next[k].level        = (in_note.attack_rate != 16'd0) ? 16'd0 : peak_new;
        end else begin
          cfg_next[k].attack       = 16'd0;
          cfg_next[k].decay        = 16'd0;
          cfg_next[k].sustain      = 16'd0;
          cfg_next[k].release_rate = 16'd0;
          env_next[k].phase        = ENV_IDLE;
          env_next[k].level        = peak_new;
        end
        // zero bend rate leaves the running bend alone
        if (in_note.bend_rate != 16'd0) begin
          cfg_next[k].bend_rate  = in_note.bend_rate;
          cfg_next[k].bend_limit = in_note.bend_limit;
          bend_now_next[k]       = 16'h0000;
        end
      end
    end
  end

  // mix: top byte of wave times top byte of level, keep the top byte
  assign mix_product = rend_wave[15:8] * rend_level[15:8];

  always_comb begin
    slot_counter_next  = slot_counter;
    env_countdown_next = env_countdown;
    last_sample_next   = last_sample;
    if (do_tick) begin
      if (render_slot) begin
        slot_counter_next = slot_counter + 1'b1;
        last_sample_next  = mix_product[15:8];
      end else begin
        slot_counter_next = '0;
        // envelope slot repeats the previous sample
        if (env_countdown != '0) begin
          env_countdown_next = env_countdown - 1'b1;
        end else begin
          env_countdown_next = envelope_divider;
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_note   <= note_t'(s_tdata);
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_VOICES; k++) begin
        cfg[k]         <= '0;
        phase_count[k] <= '0;
        wave_value[k]  <= '0;
        env[k]         <= '0;
        bend_now[k]    <= '0;
      end
      slot_counter     <= '0;
      env_countdown    <= ENV_RESET_COUNT;
      last_sample      <= '0;
      noise_lfsr       <= LFSR_SEED;
      envelope_divider <= ENV_RESET_COUNT;
    end else begin
      for (int k = 0; k < NUM_VOICES; k++) begin
        cfg[k]         <= cfg_next[k];
        phase_count[k] <= phase_count_next[k];
        wave_value[k]  <= wave_value_next[k];
        env[k]         <= env_next[k];
        bend_now[k]    <= bend_now_next[k];
      end
      slot_counter  <= slot_counter_next;
      env_countdown <= env_countdown_next;
      last_sample   <= last_sample_next;
      noise_lfsr    <= noise_lfsr_next;
      if (cfg_wr_en) begin
        envelope_divider <= cfg_wr_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      m_tdata <= last_sample_next;
    end
  end

endmodule

// ===== src/tvas_checker.sv =====
// port-level checks for the three-voice synth, bound to the top level
// depends on tvas_pkg and three_voice_adsr_synth
module tvas_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tvas_pkg::SAMPLE_W-1:0] m_tdata
);
  import tvas_pkg::*;

  // a pending sample stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("sample beat dropped or changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input side only waits on a full, stalled output register
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled while output side is free");

  // a fresh sample comes from a tick beat via the input and output registers
  a_sample_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == ACT_TICK, 2))
    else $error("sample beat without a tick beat");

endmodule

bind three_voice_adsr_synth tvas_checker u_tvas_checker (.*);
